@@ rtl/core/pzt_pkg.sv @@
// shared types and constants of the pinch zoom tracker
// used by pzt_isqrt, pzt_div10 and pinch_zoom_tracker_core; no dependencies
package pzt_pkg;

  // contact event codes
  localparam logic [2:0] CODE_TOUCH   = 3'd0;
  localparam logic [2:0] CODE_MOVE    = 3'd1;
  localparam logic [2:0] CODE_HOLD    = 3'd2;
  localparam logic [2:0] CODE_RELEASE = 3'd3;
  localparam logic [2:0] CODE_OTHER   = 3'd4;

  // report kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_ENTER = 2'd1;
  localparam logic [1:0] KIND_EXIT  = 2'd2;

  localparam int unsigned CODE_W     = 3;
  localparam int unsigned OUT_COORD_W = 12;
  localparam int unsigned CHANGE_W   = 11;
  localparam int unsigned KIND_W     = 2;

  // clamp limit is one tenth of the reference
  localparam int unsigned DIVISOR    = 10;

  // control of the iterative units
  typedef struct packed {
    logic load;
    logic step;
  } pzt_step_t;

endpackage

@@ rtl/core/pzt_isqrt.sv @@
// digit-by-digit integer square root, one root bit per step
// depends on pzt_pkg for the step control struct
module pzt_isqrt #(
  parameter int unsigned ROOT_W = 21
) (
  input  logic                    clk_i,
  input  pzt_pkg::pzt_step_t      ctrl_i,
  input  logic [2*ROOT_W-1:0]     rad_i,
  output logic [ROOT_W-1:0]       root_o
);
  import pzt_pkg::*;

  logic [2*ROOT_W-1:0] rad_q, rad_d;
  logic [ROOT_W+1:0]   rem_q, rem_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [ROOT_W+3:0]   shifted;
  logic [ROOT_W+3:0]   trial;
  logic [ROOT_W+3:0]   diff;

  // bring down the next two radicand bits and try root*4+1
  assign shifted = {rem_q, rad_q[2*ROOT_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign diff    = shifted - trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (ctrl_i.load) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (ctrl_i.step) begin
      rad_d = {rad_q[2*ROOT_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_d  = diff[ROOT_W+1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = shifted[ROOT_W+1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;

endmodule

@@ rtl/core/pzt_div10.sv @@
// division by ten through a reciprocal multiply, quotient registered on each step
// depends on pzt_pkg for the step control struct and the divisor
module pzt_div10 #(
  parameter int unsigned WIDTH = 21
) (
  input  logic                clk_i,
  input  pzt_pkg::pzt_step_t  ctrl_i,
  input  logic [WIDTH-1:0]    num_i,
  output logic [WIDTH-1:0]    quot_o
);
  import pzt_pkg::*;

  // ceil(2^SHIFT / 10) gives the exact quotient for every numerator below 2^WIDTH
  localparam int unsigned     SHIFT      = WIDTH + 4;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [WIDTH:0]  RECIP      = (WIDTH + 1)'(RECIP_FULL);

  logic [WIDTH-1:0] num_q, num_d;
  logic [WIDTH-1:0] quot_q, quot_d;
  logic [2*WIDTH:0] prod;

  assign prod = {{(WIDTH + 1){1'b0}}, num_q} * {{WIDTH{1'b0}}, RECIP};

  always_comb begin
    num_d  = num_q;
    quot_d = quot_q;
    if (ctrl_i.load) begin
      num_d = num_i;
    end else if (ctrl_i.step) begin
      quot_d = {3'b000, prod[2*WIDTH:SHIFT]};
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;

endmodule

@@ rtl/core/pinch_zoom_tracker_core.sv @@
// top level of the pinch zoom tracker: sequencer, shared multiplier, gesture state
// depends on pzt_pkg, pzt_isqrt and pzt_div10

// Each accepted word yields exactly one result word. Words that need no new
// distance (disabled, wrong stream count, no valid start, exit) go from idle
// straight to the emit state. Pinch start and pinch tracking words pass the
// states MUL_X and MUL_Y on the shared multiplier for dx*dx + dy*dy, a load
// state, then one root bit per step in the square root unit (the divide by
// ten of the reference runs alongside), then the emit state, which waits for
// a free output register, updates the state and writes the result. The
// input is accepted while the block is idle, even while an earlier result
// still waits in the output register.
module pinch_zoom_tracker_core #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 8,
  localparam int unsigned IN_BITS   = 9 + 4 * COORD_BITS,
  localparam int unsigned IN_W      = ((IN_BITS + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // num_streams, first_code, first_x, first_y, second_code, second_x, second_y
  input  logic [IN_W-1:0] s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // start_x, start_y, end_x, end_y, size_change
  output logic [63:0]     m_axis_tdata,
  // claimed, event_kind
  output logic [2:0]      m_axis_tuser
);
  import pzt_pkg::*;

  localparam int unsigned DIST_W = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned SQ_W   = 2 * COORD_BITS + 1;
  localparam int unsigned CNT_W  = $clog2(DIST_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_LOAD,
    ST_ROOT,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    ACT_IGNORE,
    ACT_DROP,
    ACT_EXIT,
    ACT_START,
    ACT_TRACK
  } action_e;

  state_e  state_q;
  action_e act_q, act_d;

  logic                  enabled_q;
  logic                  pinching_q;
  logic [DIST_W-1:0]     ref_q;
  logic [CNT_W-1:0]      cnt_q;

  // input fields
  logic [2:0]            in_num;
  logic [2:0]            in_c1, in_c2;
  logic [COORD_BITS-1:0] in_x1, in_y1, in_x2, in_y2;
  logic [COORD_BITS-1:0] x1_q, y1_q, x2_q, y2_q;
  logic [COORD_BITS-1:0] dx_q, dy_q;
  logic [SQ_W-1:0]       sq_q;

  assign in_num = s_axis_tdata[2:0];
  assign in_c1  = s_axis_tdata[5:3];
  assign in_x1  = s_axis_tdata[6 +: COORD_BITS];
  assign in_y1  = s_axis_tdata[6 + COORD_BITS +: COORD_BITS];
  assign in_c2  = s_axis_tdata[6 + 2 * COORD_BITS +: CODE_W];
  assign in_x2  = s_axis_tdata[9 + 2 * COORD_BITS +: COORD_BITS];
  assign in_y2  = s_axis_tdata[9 + 3 * COORD_BITS +: COORD_BITS];

  logic in_accept;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // decide what the word does from the gesture state
  logic c1_active, c2_active;
  assign c1_active = in_c1 <= CODE_HOLD;
  assign c2_active = in_c2 <= CODE_HOLD;

  always_comb begin
    if (!enabled_q) begin
      act_d = ACT_IGNORE;
    end else if (in_num != 3'd2) begin
      act_d = ACT_DROP;
    end else if (!pinching_q) begin
      act_d = (c1_active && c2_active) ? ACT_START : ACT_DROP;
    end else if (in_c1 == CODE_RELEASE || in_c2 == CODE_RELEASE) begin
      act_d = ACT_EXIT;
    end else begin
      act_d = ACT_TRACK;
    end
  end

  // shared multiplier, squares dx then dy
  logic [COORD_BITS-1:0]   mul_op;
  logic [2*COORD_BITS-1:0] mul_p;
  assign mul_op = (state_q == ST_MUL_X) ? dx_q : dy_q;
  assign mul_p  = mul_op * mul_op;

  // iterative units
  pzt_step_t           step_ctrl;
  logic [2*DIST_W-1:0] rad;
  logic [DIST_W-1:0]   root;
  logic [DIST_W-1:0]   tenth;

  assign step_ctrl.load = (state_q == ST_LOAD);
  assign step_ctrl.step = (state_q == ST_ROOT);
  assign rad = {1'b0, sq_q, {(2 * FRAC_BITS){1'b0}}};

  pzt_isqrt #(
    .ROOT_W (DIST_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .ctrl_i (step_ctrl),
    .rad_i  (rad),
    .root_o (root)
  );

  pzt_div10 #(
    .WIDTH (DIST_W)
  ) u_div10 (
    .clk_i  (clk_i),
    .ctrl_i (step_ctrl),
    .num_i  (ref_q),
    .quot_o (tenth)
  );

  // tracking update: clamp the change to a tenth of the reference
  logic                grow;
  logic [DIST_W-1:0]   mag;
  logic [DIST_W+3:0]   mag10;
  logic                too_big;
  logic [DIST_W-1:0]   track_ref;
  logic [DIST_W-1:0]   chg_full;
  logic [CHANGE_W-1:0] chg_mag;
  logic [CHANGE_W-1:0] track_chg;

  assign grow    = root >= ref_q;
  assign mag     = grow ? root - ref_q : ref_q - root;
  assign mag10   = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
  assign too_big = mag10 > {4'b0000, ref_q};

  always_comb begin
    if (too_big) begin
      track_ref = grow ? ref_q + tenth : ref_q - tenth;
      chg_full  = tenth >> FRAC_BITS;
    end else begin
      track_ref = root;
      chg_full  = mag >> FRAC_BITS;
    end
    chg_mag   = chg_full[CHANGE_W-1:0];
    track_chg = grow ? chg_mag : CHANGE_W'(-chg_mag);
  end

  logic out_load;
  assign out_load = (state_q == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  logic [OUT_COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [CHANGE_W-1:0]    chg_q;
  logic                   claimed_q;
  logic [KIND_W-1:0]      kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      act_q         <= ACT_IGNORE;
      enabled_q     <= 1'b1;
      pinching_q    <= 1'b0;
      ref_q         <= '0;
      cnt_q         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enabled_q <= cfg_wdata_i;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            act_q   <= act_d;
            state_q <= (act_d == ACT_START || act_d == ACT_TRACK) ? ST_MUL_X : ST_EMIT;
          end
        end
        ST_MUL_X: state_q <= ST_MUL_Y;
        ST_MUL_Y: state_q <= ST_LOAD;
        ST_LOAD: begin
          cnt_q   <= '0;
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIST_W - 1)) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
            case (act_q)
              ACT_START: begin
                pinching_q <= 1'b1;
                ref_q      <= root;
              end
              ACT_TRACK: ref_q <= track_ref;
              ACT_DROP, ACT_EXIT: pinching_q <= 1'b0;
              default: ;
            endcase
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x1_q <= in_x1;
      y1_q <= in_y1;
      x2_q <= in_x2;
      y2_q <= in_y2;
      dx_q <= (in_x1 > in_x2) ? in_x1 - in_x2 : in_x2 - in_x1;
      dy_q <= (in_y1 > in_y2) ? in_y1 - in_y2 : in_y2 - in_y1;
    end
    if (state_q == ST_MUL_X) begin
      sq_q <= SQ_W'(mul_p);
    end else if (state_q == ST_MUL_Y) begin
      sq_q <= sq_q + SQ_W'(mul_p);
    end
    if (out_load) begin
      claimed_q <= (act_q == ACT_START || act_q == ACT_TRACK);
      case (act_q)
        ACT_START, ACT_TRACK: kind_q <= KIND_ENTER;
        ACT_EXIT:             kind_q <= KIND_EXIT;
        default:              kind_q <= KIND_NONE;
      endcase
      if (act_q == ACT_START || act_q == ACT_TRACK) begin
        sx_q  <= OUT_COORD_W'(x1_q);
        sy_q  <= OUT_COORD_W'(y1_q);
        ex_q  <= OUT_COORD_W'(x2_q);
        ey_q  <= OUT_COORD_W'(y2_q);
        chg_q <= (act_q == ACT_TRACK) ? track_chg : '0;
      end else begin
        sx_q  <= '0;
        sy_q  <= '0;
        ex_q  <= '0;
        ey_q  <= '0;
        chg_q <= '0;
      end
    end
  end

  assign m_axis_tdata = {5'b00000, chg_q, ey_q, ex_q, sy_q, sx_q};
  assign m_axis_tuser = {kind_q, claimed_q};

  // an unclaimed result carries no coordinates and no change
  a_unclaimed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("unclaimed result with nonzero payload");

  // an exit is never claimed
  a_exit_unclaimed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2:1] == KIND_EXIT) |-> !m_axis_tuser[0])
    else $error("exit result marked claimed");

  // writing a claimed result leaves the tracker pinching, an unclaimed drop or exit not
  a_pinch_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (act_q == ACT_START || act_q == ACT_TRACK)) |=> pinching_q)
    else $error("pinching not set after claimed result");

  a_drop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (act_q == ACT_DROP || act_q == ACT_EXIT)) |=> !pinching_q)
    else $error("pinching not cleared after drop or exit");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench of pinch_zoom_tracker_core: stream driver, stream monitor,
// gesture predictor and stall patterns on both sides; depends on pzt_pkg and the core
module testbench;
  import pzt_pkg::*;

  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned IN_W        = 64;
  localparam int          COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam logic [2:0]  PINCH_STREAMS = 3'd2;
  localparam logic [2:0]  CODE_ODD_LO = 3'd5;
  localparam logic [2:0]  CODE_ODD_HI = 3'd7;
  localparam int          STALL_LIMIT = 4000;
  localparam int          LONG_HOLD   = 400;
  localparam int          HOLD_AT     = 700;
  localparam int          SETTLE      = 40;

  // packed in the bit order of s_axis_tdata, highest field first
  typedef struct packed {
    logic [COORD_BITS-1:0] second_y;
    logic [COORD_BITS-1:0] second_x;
    logic [CODE_W-1:0]     second_code;
    logic [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0] first_x;
    logic [CODE_W-1:0]     first_code;
    logic [2:0]            num_streams;
  } touch_item_t;

  typedef struct packed {
    logic                   claimed;
    logic [KIND_W-1:0]      kind;
    logic [OUT_COORD_W-1:0] start_x;
    logic [OUT_COORD_W-1:0] start_y;
    logic [OUT_COORD_W-1:0] end_x;
    logic [OUT_COORD_W-1:0] end_y;
    logic [CHANGE_W-1:0]    size_change;
  } pinch_report_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic            cfg_wdata_i = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [63:0]     m_axis_tdata;
  logic [2:0]      m_axis_tuser;

  pinch_zoom_tracker_core #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  touch_item_t     touch_queue[$];
  pinch_report_t   expected_reports[$];

  // predictor state
  logic            recog_on = 1'b1;
  logic            pinch_active = 1'b0;
  longint unsigned ref_dist_q = 0;

  int errors = 0;
  int reports_seen = 0;
  int idle_cycles = 0;

  function automatic longint unsigned exact_root(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // contact distance, truncated to FRAC_BITS fraction bits
  function automatic longint unsigned span_q(touch_item_t it);
    longint unsigned dx;
    longint unsigned dy;
    dx = (it.first_x > it.second_x) ? it.first_x - it.second_x : it.second_x - it.first_x;
    dy = (it.first_y > it.second_y) ? it.first_y - it.second_y : it.second_y - it.first_y;
    return exact_root((dx * dx + dy * dy) << (2 * FRAC_BITS));
  endfunction

  function automatic pinch_report_t track_pinch(touch_item_t it);
    pinch_report_t       rep;
    longint unsigned     nd;
    longint unsigned     prev;
    longint unsigned     mag;
    longint unsigned     allow;
    logic                grow;
    logic [CHANGE_W-1:0] delta;
    rep = '0;
    delta = '0;
    if (!recog_on) return rep;
    if (it.num_streams == PINCH_STREAMS) begin
      if (!pinch_active) begin
        if (it.first_code <= CODE_HOLD && it.second_code <= CODE_HOLD) begin
          pinch_active = 1'b1;
          ref_dist_q = span_q(it);
          rep.claimed = 1'b1;
          rep.kind = KIND_ENTER;
        end
      end else if (it.first_code == CODE_RELEASE || it.second_code == CODE_RELEASE) begin
        rep.kind = KIND_EXIT;
      end else begin
        nd = span_q(it);
        prev = ref_dist_q;
        grow = nd >= prev;
        mag = grow ? nd - prev : prev - nd;
        rep.claimed = 1'b1;
        rep.kind = KIND_ENTER;
        if (mag * 10 > prev) begin
          // clamp to a tenth of the reference
          allow = prev / DIVISOR;
          ref_dist_q = grow ? prev + allow : prev - allow;
          delta = CHANGE_W'(allow >> FRAC_BITS);
        end else begin
          ref_dist_q = nd;
          delta = CHANGE_W'(mag >> FRAC_BITS);
        end
        if (!grow) delta = -delta;
      end
    end
    if (!rep.claimed) pinch_active = 1'b0;
    if (rep.claimed) begin
      rep.start_x = it.first_x;
      rep.start_y = it.first_y;
      rep.end_x = it.second_x;
      rep.end_y = it.second_y;
      rep.size_change = delta;
    end
    return rep;
  endfunction

  // driver: bursts of words with random gaps between them
  touch_item_t offered;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_reports.push_back(track_pinch(offered));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (touch_queue.size() > 0) begin
          offered = touch_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {{(IN_W - $bits(touch_item_t)){1'b0}}, offered};
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: segments of always ready, coin flip or sparse ready, one long hold-off
  int  seg_left = 0;
  int  seg_mode = 0;
  int  hold_left = 0;
  logic long_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      seg_left = 0;
      hold_left = 0;
    end else begin
      if (!long_done && reports_seen >= HOLD_AT) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 50);
          seg_mode = $urandom_range(0, 2);
        end
        seg_left--;
        case (seg_mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= 1'($urandom_range(0, 1));
          end
          default: begin
            m_axis_tready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  task automatic report_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // monitor
  pinch_report_t got;
  pinch_report_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.claimed = m_axis_tuser[0];
      got.kind = m_axis_tuser[2:1];
      got.start_x = m_axis_tdata[11:0];
      got.start_y = m_axis_tdata[23:12];
      got.end_x = m_axis_tdata[35:24];
      got.end_y = m_axis_tdata[47:36];
      got.size_change = m_axis_tdata[58:48];
      reports_seen <= reports_seen + 1;
      if (expected_reports.size() == 0) begin
        report_error($sformatf("unexpected word: claimed %0d kind %0d change %0d",
                               got.claimed, got.kind, $signed(got.size_change)));
      end else begin
        want = expected_reports.pop_front();
        if (got.claimed !== want.claimed || got.kind !== want.kind ||
            got.start_x !== want.start_x || got.start_y !== want.start_y ||
            got.end_x !== want.end_x || got.end_y !== want.end_y ||
            got.size_change !== want.size_change) begin
          report_error({
            $sformatf("word %0d: exp claimed %0d kind %0d (%0d,%0d)-(%0d,%0d) change %0d",
                      reports_seen, want.claimed, want.kind, want.start_x, want.start_y,
                      want.end_x, want.end_y, $signed(want.size_change)),
            $sformatf(", got claimed %0d kind %0d (%0d,%0d)-(%0d,%0d) change %0d",
                      got.claimed, got.kind, got.start_x, got.start_y,
                      got.end_x, got.end_y, $signed(got.size_change))});
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  function automatic touch_item_t contacts(logic [2:0] n, logic [2:0] c1, int x1, int y1,
                                           logic [2:0] c2, int x2, int y2);
    touch_item_t it;
    it.num_streams = n;
    it.first_code = c1;
    it.first_x = COORD_BITS'(x1);
    it.first_y = COORD_BITS'(y1);
    it.second_code = c2;
    it.second_x = COORD_BITS'(x2);
    it.second_y = COORD_BITS'(y2);
    return it;
  endfunction

  function automatic logic [COORD_BITS-1:0] nudge(logic [COORD_BITS-1:0] c, int j);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * j)) - j;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_BITS'(v);
  endfunction

  function automatic logic [CODE_W-1:0] tracking_code();
    if ($urandom_range(0, 7) == 0) return CODE_W'($urandom_range(CODE_OTHER, CODE_ODD_HI));
    return CODE_W'($urandom_range(CODE_TOUCH, CODE_HOLD));
  endfunction

  // mostly well-formed pinches with random content, plus noise and broken gestures
  task automatic add_random_items(int count);
    int          added;
    int          moves;
    int          j;
    logic [63:0] raw;
    touch_item_t it;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 4) == 0) begin
        raw = {$urandom, $urandom};
        it = raw[$bits(touch_item_t)-1:0];
        touch_queue.push_back(it);
        added++;
      end else begin
        it.num_streams = PINCH_STREAMS;
        it.first_code = CODE_W'($urandom_range(CODE_TOUCH, CODE_HOLD));
        it.second_code = CODE_W'($urandom_range(CODE_TOUCH, CODE_HOLD));
        it.first_x = COORD_BITS'($urandom);
        it.first_y = COORD_BITS'($urandom);
        if ($urandom_range(0, 4) == 0) begin
          // contacts close together, near zero reference
          it.second_x = nudge(it.first_x, 3);
          it.second_y = nudge(it.first_y, 3);
        end else begin
          it.second_x = COORD_BITS'($urandom);
          it.second_y = COORD_BITS'($urandom);
        end
        touch_queue.push_back(it);
        added++;
        moves = $urandom_range(2, 25);
        case ($urandom_range(0, 2))
          0: j = 2;
          1: j = 12;
          default: j = 80;
        endcase
        repeat (moves) begin
          it.first_code = tracking_code();
          it.second_code = tracking_code();
          if ($urandom_range(0, 9) == 0) begin
            it.first_x = COORD_BITS'($urandom);
            it.first_y = COORD_BITS'($urandom);
            it.second_x = COORD_BITS'($urandom);
            it.second_y = COORD_BITS'($urandom);
          end else begin
            it.first_x = nudge(it.first_x, j);
            it.first_y = nudge(it.first_y, j);
            it.second_x = nudge(it.second_x, j);
            it.second_y = nudge(it.second_y, j);
          end
          it.num_streams = ($urandom_range(0, 19) == 0) ? 3'($urandom) : PINCH_STREAMS;
          touch_queue.push_back(it);
          added++;
        end
        it.num_streams = ($urandom_range(0, 3) == 0) ? 3'($urandom) : PINCH_STREAMS;
        case ($urandom_range(0, 2))
          0: it.first_code = CODE_RELEASE;
          1: it.second_code = CODE_RELEASE;
          default: begin
            it.first_code = CODE_RELEASE;
            it.second_code = CODE_RELEASE;
          end
        endcase
        touch_queue.push_back(it);
        added++;
      end
    end
  endtask

  task automatic wait_all_reported();
    @(negedge clk_i);
    while (touch_queue.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_recognition(logic on);
    wait_all_reported();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= on;
    recog_on = on;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // largest span, then collapse and regrow by the ten percent clamp
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_TOUCH, 0, 0, CODE_TOUCH,
                                   COORD_MAX, COORD_MAX));
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_MOVE, 0, 0, CODE_MOVE, 0, 0));
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_HOLD, COORD_MAX, COORD_MAX,
                                   CODE_HOLD, 0, 0));
    // other and unknown codes keep tracking
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_OTHER, COORD_MAX, COORD_MAX,
                                   CODE_MOVE, 7, 3));
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_ODD_HI, COORD_MAX, 4000,
                                   CODE_ODD_LO, 9, 3));
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_RELEASE, 10, 10, CODE_MOVE, 20, 20));
    // no valid start
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_MOVE, 10, 10, CODE_RELEASE, 20, 20));
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_HOLD, 10, 10, CODE_OTHER, 20, 20));
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_ODD_LO, 10, 10, CODE_TOUCH, 20, 20));
    // zero reference stays zero
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_TOUCH, 100, 100, CODE_TOUCH, 100, 100));
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_MOVE, 100, 100, CODE_MOVE, 200, 100));
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_MOVE, 100, 100, CODE_MOVE, 100, 100));
    // wrong stream counts
    touch_queue.push_back(contacts(3'd3, CODE_MOVE, 1, 2, CODE_MOVE, 3, 4));
    touch_queue.push_back(contacts(3'd0, CODE_TOUCH, 0, 0, CODE_TOUCH, 5, 5));
    touch_queue.push_back(contacts(3'd1, CODE_TOUCH, 0, 0, CODE_TOUCH, 5, 5));
    touch_queue.push_back(contacts(3'd7, CODE_TOUCH, 0, 0, CODE_TOUCH, 5, 5));
    // unclamped growth and an unclamped shrink just under ten percent
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_TOUCH, 1000, 1000, CODE_HOLD,
                                   1100, 1000));
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_MOVE, 1000, 1000, CODE_MOVE,
                                   1105, 1000));
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_MOVE, 1000, 1000, CODE_MOVE,
                                   1095, 1000));
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_MOVE, 1000, 1000, CODE_RELEASE,
                                   1095, 1000));
    touch_queue.push_back(contacts(3'd4, CODE_ODD_HI, COORD_MAX, 0, CODE_ODD_HI, 0,
                                   COORD_MAX));
    touch_queue.push_back(contacts(PINCH_STREAMS, CODE_TOUCH, 100, 100, CODE_TOUCH,
                                   300, 100));
    set_recognition(1'b0);
    // state is kept while off: start a pinch first, then items while disabled
    add_random_items(40);
    set_recognition(1'b1);
    add_random_items(800);
    set_recognition(1'b0);
    add_random_items(30);
    set_recognition(1'b1);
    add_random_items(660);
    wait_all_reported();
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
